>>> src/skt_pkg.sv
// Shared types and codes for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // Commands broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

>>> src/skt_if.sv
// Request and response channel interfaces of the sorted key table.
`timescale 1ns / 1ps

interface skt_req_if #(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 48
);
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [KEY_WIDTH-1:0]     key;
  logic [PAYLOAD_WIDTH-1:0] entry_data;

  modport source (output valid, kind, key, entry_data, input ready);
  modport sink   (input valid, kind, key, entry_data, output ready);
endinterface

interface skt_rsp_if #(
  parameter int IDX_WIDTH = 4
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [IDX_WIDTH-1:0] position;
  logic [IDX_WIDTH-1:0] count;

  modport source (output valid, status, position, count, input ready);
  modport sink   (input valid, status, position, count, output ready);
endinterface

>>> src/sorted_key_table_core.sv
// Top level of the sorted key table: controller and the row of cells.
`timescale 1ns / 1ps

// A table of up to DEPTH entries kept in ascending key order in a row of
// cells, one entry per cell. Each request item is an insert or a delete;
// each returns one response item with a status, the slot found and the
// entry count afterwards. An item is registered at acceptance, every cell
// compares its key against it in parallel in the compare state, and in the
// update state the row shifts left or right in one step while the response
// is loaded into the output register; the update waits while an earlier
// response is still untaken. The request side is ready again right after
// that, even while the response waits to be taken, but takes no new item
// until the current one has been updated. The table resets empty.

module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int DEPTH         = 8,
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 48
) (
  input  logic  clk,
  input  logic  rst,
  skt_req_if.sink   req,
  skt_rsp_if.source rsp
);

  localparam int IDX_WIDTH = $clog2(DEPTH + 1);

  state_t state;
  state_t state_next;

  logic                     kind_r;
  logic [KEY_WIDTH-1:0]     key_r;
  logic [PAYLOAD_WIDTH-1:0] payload_r;
  logic [IDX_WIDTH-1:0]     count;

  logic                 out_valid;
  status_t              out_status;
  logic [IDX_WIDTH-1:0] out_position;
  logic [IDX_WIDTH-1:0] out_count;

  cell_ctrl_t cell_ctrl;

  logic [DEPTH-1:0]         lt;
  logic [DEPTH-1:0]         eq;
  logic [DEPTH-1:0]         lt_left;
  logic [KEY_WIDTH-1:0]     keys     [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] payloads [DEPTH];

  logic                 hit;
  logic                 full;
  logic                 out_free;
  logic [IDX_WIDTH-1:0] pos;
  status_t              status_next;
  logic [IDX_WIDTH-1:0] count_next;

  // Row of cells.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [KEY_WIDTH-1:0]     lkey;
    logic [PAYLOAD_WIDTH-1:0] lpay;
    logic [KEY_WIDTH-1:0]     rkey;
    logic [PAYLOAD_WIDTH-1:0] rpay;

    if (gi == 0) begin : g_first
      assign lt_left[gi] = 1'b1;
      assign lkey        = key_r;
      assign lpay        = payload_r;
    end else begin : g_mid
      assign lt_left[gi] = lt[gi-1];
      assign lkey        = keys[gi-1];
      assign lpay        = payloads[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_last
      assign rkey = key_r;
      assign rpay = payload_r;
    end else begin : g_inner
      assign rkey = keys[gi+1];
      assign rpay = payloads[gi+1];
    end

    skt_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctrl          (cell_ctrl),
      .occupied      (count > IDX_WIDTH'(gi)),
      .lt_left       (lt_left[gi]),
      .ins_key       (key_r),
      .ins_payload   (payload_r),
      .left_key      (lkey),
      .left_payload  (lpay),
      .right_key     (rkey),
      .right_payload (rpay),
      .lt            (lt[gi]),
      .eq            (eq[gi]),
      .key           (keys[gi]),
      .payload       (payloads[gi])
    );
  end

  // The boundary between smaller keys and the rest is a single cell, so
  // its index is an OR over the one-hot boundary flags.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!lt[i] && lt_left[i]) begin
        pos = pos | IDX_WIDTH'(i);
      end
    end
    if (lt[DEPTH-1]) begin
      pos = IDX_WIDTH'(DEPTH);
    end
  end

  assign hit      = |eq;
  assign full     = (count == IDX_WIDTH'(DEPTH));
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    count_next = count;
    if (kind_r == KIND_INSERT) begin
      priority if (hit) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + IDX_WIDTH'(1);
      end
    end else begin
      if (hit) begin
        status_next = ST_DELETED;
        count_next  = count - IDX_WIDTH'(1);
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    req.ready     = (state == S_IDLE) && !rst;
    cell_ctrl.cmp = (state == S_CMP);
    cell_ctrl.ins = (state == S_UPD) && out_free && (status_next == ST_INSERTED);
    cell_ctrl.del = (state == S_UPD) && out_free && (status_next == ST_DELETED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPD && out_free) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_r    <= req.kind;
      key_r     <= req.key;
      payload_r <= req.entry_data;
    end
    if (state == S_UPD && out_free) begin
      out_status   <= status_next;
      out_position <= pos;
      out_count    <= count_next;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_position;
  assign rsp.count    = out_count;

endmodule

>>> src/skt_cell.sv
// One slot of the sorted row: holds a key and payload, compares and shifts.
`timescale 1ns / 1ps

module skt_cell
  import skt_pkg::*;
#(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 48
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     occupied,
  input  logic                     lt_left,
  input  logic [KEY_WIDTH-1:0]     ins_key,
  input  logic [PAYLOAD_WIDTH-1:0] ins_payload,
  input  logic [KEY_WIDTH-1:0]     left_key,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  logic [KEY_WIDTH-1:0]     right_key,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload,
  output logic                     lt,
  output logic                     eq,
  output logic [KEY_WIDTH-1:0]     key,
  output logic [PAYLOAD_WIDTH-1:0] payload
);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= occupied && (key < ins_key);
      eq <= occupied && (key == ins_key);
    end
  end

  // Cells below the insertion point hold; the boundary cell takes the new
  // item and every cell above it takes its left neighbor's entry. A delete
  // pulls everything from the hit slot upward one place to the left.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      if (lt_left) begin
        key     <= ins_key;
        payload <= ins_payload;
      end else begin
        key     <= left_key;
        payload <= left_payload;
      end
    end else if (ctrl.del && !lt) begin
      key     <= right_key;
      payload <= right_payload;
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sorted key table: directed table, random items, idle phases.
`timescale 1ns / 1ps

module testbench;
  import skt_pkg::*;

  localparam int DEPTH         = 8;
  localparam int KEY_WIDTH     = 16;
  localparam int PAYLOAD_WIDTH = 48;
  localparam int IDX_WIDTH     = 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 290;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    status_t              status;
    logic [IDX_WIDTH-1:0] position;
    logic [IDX_WIDTH-1:0] count;
  } table_result_t;

  typedef struct {
    kind_t                    kind;
    logic [KEY_WIDTH-1:0]     key;
    logic [PAYLOAD_WIDTH-1:0] data;
    bit                       typed;
    table_result_t            want;
  } table_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skt_req_if #(.KEY_WIDTH(KEY_WIDTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) req_ch ();
  skt_rsp_if #(.IDX_WIDTH(IDX_WIDTH)) rsp_ch ();

  sorted_key_table_core #(
    .DEPTH        (DEPTH),
    .KEY_WIDTH    (KEY_WIDTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table, kept in step with accepted items.
  logic [KEY_WIDTH-1:0]     shadow_keys[DEPTH];
  logic [PAYLOAD_WIDTH-1:0] shadow_data[DEPTH];
  int                       shadow_count = 0;

  table_result_t pending_results[$];
  int            mismatches = 0;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_seq      = 0;

  // Typed expectation of the item now on the request channel, if any.
  bit            item_typed = 1'b0;
  table_result_t item_want;

  table_op_t     directed_ops[$];
  logic [KEY_WIDTH-1:0] key_pool[12];

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic table_result_t apply_table_op(input kind_t kind,
                                                   input logic [KEY_WIDTH-1:0] key,
                                                   input logic [PAYLOAD_WIDTH-1:0] data);
    table_result_t res;
    int            slot;
    bit            hit;
    slot = 0;
    while (slot < shadow_count && shadow_keys[slot] < key) slot++;
    hit = (slot < shadow_count) && (shadow_keys[slot] == key);
    if (kind == KIND_INSERT) begin
      if (hit) begin
        res.status = ST_DUPLICATE;
      end else if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (int i = shadow_count; i > slot; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_data[i] = shadow_data[i-1];
        end
        shadow_keys[slot] = key;
        shadow_data[slot] = data;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (hit) begin
        for (int i = slot + 1; i < shadow_count; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
          shadow_data[i-1] = shadow_data[i];
        end
        shadow_count--;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.position = IDX_WIDTH'(slot);
    res.count    = IDX_WIDTH'(shadow_count);
    return res;
  endfunction

  // Check responses against the oldest expectation, then predict for the new request.
  always @(posedge clk) begin
    table_result_t want;
    table_result_t predicted;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("response item with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
          if (rsp_ch.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      rsp_ch.position, want.position));
          if (rsp_ch.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp_ch.count, want.count));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        predicted = apply_table_op(kind_t'(req_ch.kind), req_ch.key, req_ch.entry_data);
        pending_results.push_back(item_typed ? item_want : predicted);
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Response side: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin : rsp_ready_driver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic add_op(input kind_t kind, input logic [KEY_WIDTH-1:0] key,
                        input logic [PAYLOAD_WIDTH-1:0] data, input bit typed,
                        input status_t status = ST_INSERTED, input int position = 0,
                        input int count = 0);
    table_op_t op;
    op.kind          = kind;
    op.key           = key;
    op.data          = data;
    op.typed         = typed;
    op.want.status   = status;
    op.want.position = IDX_WIDTH'(position);
    op.want.count    = IDX_WIDTH'(count);
    directed_ops.push_back(op);
  endtask

  task automatic send_op(input table_op_t op);
    int gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.kind       = op.kind;
    req_ch.key        = op.key;
    req_ch.entry_data = op.data;
    item_typed        = op.typed;
    item_want         = op.want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic table_op_t random_op(input int insert_pct);
    table_op_t op;
    op.kind  = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
    op.key   = ($urandom_range(99) < 75) ? key_pool[$urandom_range(11)]
                                         : KEY_WIDTH'($urandom);
    op.data  = {16'($urandom), 32'($urandom)};
    op.typed = 1'b0;
    op.want  = '0;
    return op;
  endfunction

  task automatic refill_key_pool();
    for (int i = 0; i < 12; i++) key_pool[i] = KEY_WIDTH'($urandom);
    // Keep the extremes of the key range in play.
    key_pool[0] = '0;
    key_pool[1] = '1;
  endtask

  initial begin : stimulus
    int src_pcts[4];
    int snk_pcts[4];
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_INSERT;
    req_ch.key        = '0;
    req_ch.entry_data = '0;
    item_want         = '0;
    src_pcts = '{0, 78, 0, 31};
    snk_pcts = '{0, 0, 78, 31};

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Empty table, extremes of key and payload, filling to capacity, then unwinding.
    add_op(KIND_DELETE, 16'h0000, 48'h0, 1'b1, ST_NOT_FOUND, 0, 0);
    add_op(KIND_INSERT, 16'hFFFF, '1, 1'b1, ST_INSERTED, 0, 1);
    add_op(KIND_INSERT, 16'h0000, 48'h0, 1'b1, ST_INSERTED, 0, 2);
    add_op(KIND_INSERT, 16'hFFFF, 48'h123, 1'b1, ST_DUPLICATE, 1, 2);
    for (int i = 1; i <= 6; i++)
      add_op(KIND_INSERT, KEY_WIDTH'(i * 16'h1000), {8{6'(i)}}, 1'b0);
    add_op(KIND_INSERT, 16'h0000, '1, 1'b1, ST_DUPLICATE, 0, 8);
    add_op(KIND_INSERT, 16'h8000, 48'h5A5A, 1'b0);
    add_op(KIND_INSERT, 16'h0001, 48'hA5A5, 1'b0);
    add_op(KIND_DELETE, 16'h0000, '1, 1'b1, ST_DELETED, 0, 7);
    add_op(KIND_DELETE, 16'hFFFF, 48'h0, 1'b1, ST_DELETED, 6, 6);
    add_op(KIND_DELETE, 16'h3000, '1, 1'b0);
    add_op(KIND_DELETE, 16'h3000, 48'h0, 1'b0);
    add_op(KIND_INSERT, 16'h5555, 48'hAAAA_AAAA_AAAA, 1'b0);
    add_op(KIND_INSERT, 16'hAAAA, 48'h5555_5555_5555, 1'b0);
    add_op(KIND_DELETE, 16'h7FFF, 48'h0, 1'b0);
    add_op(KIND_INSERT, 16'h8000, 48'h0, 1'b0);
    foreach (directed_ops[i]) send_op(directed_ops[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_pcts[ph];
      snk_stall_pct = snk_pcts[ph];
      refill_key_pool();
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_op(random_op((n / 50) % 2 == 0 ? 62 : 45));
      wait_drained();
    end

    // Response side holds off while requests keep coming, so the input backs up.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    refill_key_pool();
    @(posedge clk);
    hold_seq++;
    for (int n = 0; n < 24; n++) send_op(random_op(55));
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
